>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions used by the top-level design file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/btpi_pkg.sv
// ---------------------------------------------------------------------------
// btpi_pkg
// shared types and constants of the trie path insert block
// ---------------------------------------------------------------------------
package btpi_pkg;

  // symbols 0..SYMBOLS-1 walk the trie, END_SYMBOL closes a key
  localparam int unsigned SYMBOLS    = 129;
  localparam logic [7:0]  END_SYMBOL = 8'd129;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned OUT_W      = 8;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_step;   // write one empty entry of the clearing pass
    logic take_walk;  // accept a walking symbol, issue the child read
    logic take_end;   // accept end of key, emit result
    logic resolve;    // use the child read data
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing pass at its last entry
    logic sym_end;    // incoming symbol closes the key
    logic sym_walk;   // incoming symbol needs a table lookup
  } sts_t;

endpackage

>>> design/btpi_ctrl.sv
// ---------------------------------------------------------------------------
// btpi_ctrl
// sequencer: clearing pass after reset, then accept and look up symbols
// ---------------------------------------------------------------------------
module btpi_ctrl
  import btpi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.take_end  = sts_i.sym_end;
          cmd_o.take_walk = sts_i.sym_walk;
          if (sts_i.sym_walk) begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        cmd_o.resolve = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

>>> design/btpi_dpath.sv
// ---------------------------------------------------------------------------
// btpi_dpath
// child table memory, current node, allocation counter and result register
// ---------------------------------------------------------------------------
module btpi_dpath
  import btpi_pkg::*;
#(
  parameter int unsigned MAX_NODES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SYM_W-1:0] symbol_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             done_o,
  output logic [OUT_W-1:0] end_node_o,
  output logic             overflow_o
);

  localparam int unsigned NW    = $clog2(MAX_NODES);
  localparam int unsigned DEPTH = MAX_NODES * SYMBOLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EW    = NW + 1;

  // entry: {valid, child node}
  logic [EW-1:0] child_mem [DEPTH];
  logic [EW-1:0] rd_q;

  logic [NW-1:0]  cur_q, cur_d;
  logic [NW:0]    used_q, used_d;
  logic           ovf_q, ovf_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [AW-1:0]  addr_q, addr_d;
  logic           done_q, done_d;
  logic [OUT_W-1:0] end_node_q, end_node_d;
  logic           ovf_out_q, ovf_out_d;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [EW-1:0]  wdata;
  logic           hit;
  logic           full;
  logic [NW+OUT_W-1:0] cur_ext;

  assign addr_d  = AW'(cur_q) * AW'(SYMBOLS) + AW'(symbol_i);
  assign hit     = rd_q[NW];
  assign full    = (used_q == (NW+1)'(MAX_NODES));
  assign cur_ext = {{OUT_W{1'b0}}, cur_q};

  assign sts_o.clr_last = (clr_q == AW'(DEPTH - 1));
  assign sts_o.sym_end  = (symbol_i == END_SYMBOL);
  assign sts_o.sym_walk = (symbol_i < SYM_W'(SYMBOLS)) && !ovf_q;

  // write port: clearing pass or allocation of a new child
  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = {1'b1, used_q[NW-1:0]};
    if (cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (cmd_i.resolve && !hit && !full) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      child_mem[waddr] <= wdata;
    end
    if (cmd_i.take_walk) begin
      rd_q <= child_mem[addr_d];
    end
  end

  always_comb begin
    cur_d      = cur_q;
    used_d     = used_q;
    ovf_d      = ovf_q;
    clr_d      = clr_q;
    done_d     = 1'b0;
    end_node_d = end_node_q;
    ovf_out_d  = ovf_out_q;
    if (cmd_i.clr_step) begin
      clr_d = clr_q + AW'(1);
    end
    if (cmd_i.take_end) begin
      done_d     = 1'b1;
      end_node_d = ovf_q ? '0 : cur_ext[OUT_W-1:0];
      ovf_out_d  = ovf_q;
      cur_d      = '0;
      ovf_d      = 1'b0;
    end
    if (cmd_i.resolve) begin
      if (hit) begin
        cur_d = rd_q[NW-1:0];
      end else if (full) begin
        ovf_d = 1'b1;
      end else begin
        cur_d  = used_q[NW-1:0];
        used_d = used_q + (NW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      used_q <= (NW+1)'(1);
      ovf_q  <= 1'b0;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      used_q <= used_d;
      ovf_q  <= ovf_d;
      clr_q  <= clr_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_walk) begin
      addr_q <= addr_d;
    end
    end_node_q <= end_node_d;
    ovf_out_q  <= ovf_out_d;
  end

  assign done_o     = done_q;
  assign end_node_o = end_node_q;
  assign overflow_o = ovf_out_q;

endmodule

>>> design/byte_trie_path_insert.sv
// ---------------------------------------------------------------------------
// byte_trie_path_insert
// inserts keys, fed one symbol per transaction, into a trie node store
// ---------------------------------------------------------------------------
// usage:
//   a symbol is taken when start is high and busy is low. symbols below 129
//   walk the trie from the current node and allocate a node where the child
//   is missing; 129 closes the key; symbols above 129 are dropped.
//   closing a key puts end_node_o and overflow_o on the ports with done_o
//   high for one cycle, in the cycle after the transaction; there is no stall.
//   a walking symbol keeps busy high in the cycle after it is taken, for
//   the registered read of the child table that the next symbol depends on.
//   end-of-key and dropped symbols leave busy low, so results never block
//   the input side.
//   after reset busy stays high for a clearing pass over MAX_NODES * 129 table
//   entries (33024 at the default), writing one empty table entry a cycle.
//   once a node is needed while the store is full, the rest of the key is
//   ignored and the result reports overflow with end_node zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_trie_path_insert
  import btpi_pkg::*;
#(
  parameter int unsigned MAX_NODES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [SYM_W-1:0] symbol_i,
  output logic             busy,
  output logic             done_o,
  output logic [OUT_W-1:0] end_node_o,
  output logic             overflow_o
);

  cmd_t cmd;
  sts_t sts;

  btpi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  btpi_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .symbol_i   (symbol_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .done_o     (done_o),
    .end_node_o (end_node_o),
    .overflow_o (overflow_o)
  );

  `ASSERT_IMPL(a_done_after_end, done_o, $past(start && !busy && sts.sym_end), "stray result")
  `ASSERT_NEXT(a_walk_then_busy, cmd.take_walk, busy && cmd.resolve, "walk without lookup cycle")
  `ASSERT_IMPL(a_resolve_after_read, cmd.resolve, $past(cmd.take_walk), "lookup without read")

endmodule

>>> sim/tb_byte_trie_path_insert.sv
// ---------------------------------------------------------------------------
// tb_byte_trie_path_insert
// self-checking bench for the trie path insert block: symbol streams of
// fresh, replayed, extended and truncated keys with ignored noise symbols
// mixed in, checked against a behavioral trie kept in the bench
// ---------------------------------------------------------------------------
module tb_byte_trie_path_insert;
  import btpi_pkg::*;

  localparam int unsigned NODE_CAP   = 256;
  localparam int unsigned TABLE_LEN  = NODE_CAP * SYMBOLS;
  localparam logic [8:0]  NO_CHILD   = 9'h1FF;
  localparam int unsigned RAND_ITEMS = 1750;
  localparam int unsigned CYCLE_CAP  = 250000;
  localparam int unsigned DRAIN_CYC  = 10;

  typedef struct {
    logic [SYM_W-1:0] sym;
    int unsigned      idle_pct;
  } sym_item_t;

  typedef struct {
    logic [OUT_W-1:0] end_node;
    logic             overflow;
  } key_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic [SYM_W-1:0] symbol_i;
  logic             busy;
  logic             done_o;
  logic [OUT_W-1:0] end_node_o;
  logic             overflow_o;

  // behavioral trie
  logic [8:0]  trie_child [TABLE_LEN];
  int unsigned trie_cur;
  int unsigned trie_used;
  logic        trie_ovf;

  sym_item_t   symbol_feed [$];
  key_result_t key_results_due [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  byte_trie_path_insert #(
    .MAX_NODES(NODE_CAP)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .symbol_i  (symbol_i),
    .busy      (busy),
    .done_o    (done_o),
    .end_node_o(end_node_o),
    .overflow_o(overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // walk one accepted symbol through the trie, queue the key result on end of key
  task automatic insert_symbol(input logic [SYM_W-1:0] sym);
    key_result_t r;
    int unsigned slot;
    logic [8:0]  nxt;
    if (sym == END_SYMBOL) begin
      r.end_node = trie_ovf ? '0 : trie_cur[OUT_W-1:0];
      r.overflow = trie_ovf;
      key_results_due.push_back(r);
      trie_cur = 0;
      trie_ovf = 1'b0;
    end else if (sym < SYMBOLS && !trie_ovf) begin
      slot = trie_cur * SYMBOLS + sym;
      nxt  = trie_child[slot];
      if (nxt == NO_CHILD) begin
        if (trie_used >= NODE_CAP) begin
          trie_ovf = 1'b1;
        end else begin
          nxt = trie_used[8:0];
          trie_child[slot] = nxt;
          trie_used++;
        end
      end
      if (!trie_ovf) trie_cur = nxt;
    end
  endtask

  task automatic push_sym(input logic [SYM_W-1:0] sym, input int unsigned pct);
    sym_item_t it;
    it.sym      = sym;
    it.idle_pct = pct;
    symbol_feed.push_back(it);
  endtask

  // mostly a small alphabet so keys share prefixes and the trie grows deep
  function automatic logic [SYM_W-1:0] rand_walk_sym();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return SYM_W'($urandom_range(0, 3));
    if (pick < 75) return SYM_W'(127);
    if (pick < 80) return SYM_W'(128);
    return SYM_W'($urandom_range(0, 128));
  endfunction

  // driver: hold start until the transaction is taken, then maybe idle
  always @(posedge clk_i) begin : drive_p
    logic             take;
    logic             nxt_start;
    logic [SYM_W-1:0] nxt_sym;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      take      = start && !busy;
      nxt_start = start && !take;
      nxt_sym   = symbol_i;
      if (take) insert_symbol(symbol_i);
      if (!nxt_start && symbol_feed.size() != 0) begin
        if ($urandom_range(99) >= symbol_feed[0].idle_pct) begin
          nxt_sym   = symbol_feed[0].sym;
          nxt_start = 1'b1;
          symbol_feed.pop_front();
        end
      end
      start    <= nxt_start;
      symbol_i <= nxt_sym;
    end
  end

  // monitor: every strobed result against the oldest queued key result
  always @(posedge clk_i) begin : check_p
    key_result_t want;
    if (rst_ni && done_o) begin
      if (key_results_due.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result: expected none, got end_node %0d overflow %0b",
                 $time, end_node_o, overflow_o);
      end else begin
        want = key_results_due.pop_front();
        if (end_node_o !== want.end_node) begin
          mismatch_cnt++;
          $display("%0t: end_node mismatch: expected %0d, got %0d",
                   $time, want.end_node, end_node_o);
        end
        if (overflow_o !== want.overflow) begin
          mismatch_cnt++;
          $display("%0t: overflow mismatch: expected %0b, got %0b",
                   $time, want.overflow, overflow_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog_p
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stim_p
    logic [SYM_W-1:0] key_buf [$];
    logic [SYM_W-1:0] key_pool [$];
    int unsigned      key_start [$];
    int unsigned      key_len [$];
    int unsigned      walk_cnt;
    int unsigned      pct;
    int unsigned      phase;
    int unsigned      kind;
    int unsigned      idx;
    int unsigned      n;

    start    = 1'b0;
    symbol_i = '0;
    rst_ni   = 1'b0;
    foreach (trie_child[i]) trie_child[i] = NO_CHILD;
    trie_cur  = 0;
    trie_used = 1;
    trie_ovf  = 1'b0;

    // directed: empty keys, edge symbols, ignored symbols, path reuse
    push_sym(END_SYMBOL, 0);
    push_sym(8'd0, 0);   push_sym(END_SYMBOL, 0);
    push_sym(8'd128, 0); push_sym(END_SYMBOL, 0);
    push_sym(8'd127, 0); push_sym(END_SYMBOL, 0);
    push_sym(8'd255, 0); push_sym(8'd130, 0);
    push_sym(8'd0, 0);   push_sym(END_SYMBOL, 0);
    push_sym(8'd0, 0);   push_sym(8'd128, 0); push_sym(8'd127, 0);
    push_sym(END_SYMBOL, 0);
    push_sym(END_SYMBOL, 0);
    push_sym(8'd1, 0);   push_sym(8'd2, 0);   push_sym(8'd3, 0);
    push_sym(8'd255, 0); push_sym(END_SYMBOL, 0);

    // random keys; the store fills early, so later results mix reuse and overflow
    walk_cnt = 0;
    while (walk_cnt < RAND_ITEMS) begin
      phase = walk_cnt * 4 / RAND_ITEMS;
      pct   = (phase == 1) ? 66 : (phase == 3) ? 28 : 0;
      kind  = $urandom_range(99);
      key_buf.delete();
      if (kind < 55 && key_len.size() != 0) begin
        idx = $urandom_range(key_len.size() - 1);
        n   = key_len[idx];
        // truncated replay stops on an inner node of an existing path
        if (kind >= 45 && n != 0) n = $urandom_range(n - 1);
        for (int k = 0; k < n; k++) key_buf.push_back(key_pool[key_start[idx] + k]);
        if (kind >= 30 && kind < 45) begin
          n = $urandom_range(1, 3);
          for (int k = 0; k < n; k++) key_buf.push_back(rand_walk_sym());
        end
      end else begin
        n = $urandom_range(0, 8);
        for (int k = 0; k < n; k++) key_buf.push_back(rand_walk_sym());
      end
      key_start.push_back(key_pool.size());
      key_len.push_back(key_buf.size());
      foreach (key_buf[k]) begin
        key_pool.push_back(key_buf[k]);
        if ($urandom_range(99) < 4) push_sym(SYM_W'($urandom_range(130, 255)), pct);
        push_sym(key_buf[k], pct);
        walk_cnt++;
      end
      push_sym(END_SYMBOL, pct);
      walk_cnt++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (symbol_feed.size() != 0 || start || key_results_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (key_results_due.size() != 0) begin
      mismatch_cnt++;
      $display("%0t: missing results: expected %0d more, got none",
               $time, key_results_due.size());
    end
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/btpi_pkg.sv
design/btpi_ctrl.sv
design/btpi_dpath.sv
design/byte_trie_path_insert.sv
sim/tb_byte_trie_path_insert.sv
